@@ src/tcw_pkg.sv @@
// Shared types and constants of the text console writer.
// Depends on nothing; every other file of the block uses it by scoped names.
`default_nettype none

package tcw_pkg;

	localparam int unsigned COLUMNS = 80;
	localparam int unsigned ROWS    = 25;
	localparam int unsigned CELLS   = COLUMNS * ROWS;

	localparam int unsigned CELL_W = 11;
	localparam int unsigned COL_W  = $clog2(COLUMNS);

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);

	typedef logic [CELL_W-1:0] tcw_cell_t;
	typedef logic [COL_W-1:0]  tcw_col_t;

	localparam tcw_cell_t LAST_CELL  = CELL_W'(CELLS - 1);
	localparam tcw_cell_t SCAN_END   = CELL_W'(CELLS);
	localparam tcw_cell_t LAST_ROW   = CELL_W'(CELLS - COLUMNS);
	localparam tcw_cell_t ROW_STRIDE = CELL_W'(COLUMNS);
	localparam tcw_col_t  LAST_COL   = COL_W'(COLUMNS - 1);

	localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
	localparam logic [7:0] BLANK_CHAR   = 8'h20;
	localparam logic [7:0] NULL_CHAR    = 8'h00;
	localparam logic [7:0] COLOUR_RESET = 8'h0A;

	localparam logic CMD_PUT  = 1'b0;
	localparam logic CMD_READ = 1'b1;

	typedef enum logic [1:0] {
		OP_PUT     = 2'd0,
		OP_NEWLINE = 2'd1,
		OP_NOP     = 2'd2,
		OP_READ    = 2'd3
	} tcw_op_t;

	typedef struct packed {
		tcw_op_t    op;
		logic [7:0] ch;
		tcw_cell_t  addr;
		logic       in_range;
	} tcw_cmd_t;

	typedef struct packed {
		tcw_cell_t  cursor_cell;
		logic [7:0] read_char;
		logic [7:0] read_attr;
		logic       scrolled;
	} tcw_res_t;

	typedef struct packed {
		logic full;
		logic empty;
	} tcw_fifo_stat_t;

endpackage

`default_nettype wire

@@ src/tcw_front.sv @@
// Input stage: accepts items, classifies them into commands, hands them to the queue.
// Depends on tcw_pkg.
`default_nettype none

module tcw_front (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     push,
	output logic                    full,
	input  wire                     cmd,
	input  wire  [7:0]              ch,
	input  wire  [10:0]             cell_req,
	input  wire                     clearing,
	input  wire tcw_pkg::tcw_fifo_stat_t fifo_stat,
	output logic                    cmd_push,
	output tcw_pkg::tcw_cmd_t       cmd_item
);

	logic              valid_s1;
	tcw_pkg::tcw_cmd_t item_s1;
	tcw_pkg::tcw_cmd_t item_cls;
	logic              accept;

	always_comb begin
		item_cls.ch       = ch;
		item_cls.addr     = cell_req;
		item_cls.in_range = (cell_req < tcw_pkg::SCAN_END);
		if (cmd == tcw_pkg::CMD_READ) begin
			item_cls.op = tcw_pkg::OP_READ;
		end else if (ch == tcw_pkg::NULL_CHAR) begin
			item_cls.op = tcw_pkg::OP_NOP;
		end else if (ch == tcw_pkg::NEWLINE_CHAR) begin
			item_cls.op = tcw_pkg::OP_NEWLINE;
		end else begin
			item_cls.op = tcw_pkg::OP_PUT;
		end
	end

	assign full     = clearing || (valid_s1 && fifo_stat.full);
	assign accept   = push && !full;
	assign cmd_push = valid_s1 && !fifo_stat.full;
	assign cmd_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (!fifo_stat.full) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_cls;
		end
	end

endmodule

`default_nettype wire

@@ src/tcw_cmd_fifo.sv @@
// Short command queue between the input stage and the screen engine.
// Depends on tcw_pkg.
`default_nettype none

module tcw_cmd_fifo (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     wr_en,
	input  wire tcw_pkg::tcw_cmd_t  wr_data,
	input  wire                     rd_en,
	output tcw_pkg::tcw_cmd_t       rd_data,
	output tcw_pkg::tcw_fifo_stat_t stat
);

	tcw_pkg::tcw_cmd_t                   entry_q [tcw_pkg::FIFO_DEPTH];
	logic [tcw_pkg::FIFO_PTR_W-1:0]      wr_ptr_q;
	logic [tcw_pkg::FIFO_PTR_W-1:0]      rd_ptr_q;
	logic [tcw_pkg::FIFO_PTR_W:0]        count_q;
	logic                                do_wr;
	logic                                do_rd;

	assign stat.full  = (count_q == (tcw_pkg::FIFO_PTR_W + 1)'(tcw_pkg::FIFO_DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_wr      = wr_en && !stat.full;
	assign do_rd      = rd_en && !stat.empty;
	assign rd_data    = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

@@ src/tcw_back.sv @@
// Screen engine: screen store, cursor, scroll and clearing sweeps, result register.
// Depends on tcw_pkg.
`default_nettype none

module tcw_back (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cfg_valid,
	input  wire  [7:0]         cfg_colour,
	input  wire tcw_pkg::tcw_cmd_t cmd_item,
	input  wire                cmd_empty,
	output logic               cmd_pop,
	output logic               clearing,
	output logic               res_valid,
	input  wire                res_pop,
	output tcw_pkg::tcw_res_t  res
);

	typedef enum logic [4:0] {
		ST_CLEAR     = 5'b00001,
		ST_IDLE      = 5'b00010,
		ST_READ_WAIT = 5'b00100,
		ST_SCROLL    = 5'b01000,
		ST_FILL      = 5'b10000
	} tcw_state_t;

	tcw_state_t          state_q;
	tcw_pkg::tcw_cell_t  cursor_q;
	tcw_pkg::tcw_col_t   col_q;
	logic [7:0]          colour_q;
	tcw_pkg::tcw_cell_t  sweep_q;
	logic                rd_valid_s1;
	tcw_pkg::tcw_cell_t  rd_addr_s1;
	logic [15:0]         rd_data_q;
	logic [15:0]         mem [tcw_pkg::CELLS];
	logic                out_valid_q;
	tcw_pkg::tcw_res_t   out_q;

	logic                mem_we;
	tcw_pkg::tcw_cell_t  mem_waddr;
	logic [15:0]         mem_wdata;
	logic                mem_re;
	tcw_pkg::tcw_cell_t  mem_raddr;

	tcw_pkg::tcw_cell_t  nxt_cursor;
	tcw_pkg::tcw_col_t   nxt_col;
	logic                go_scroll;
	tcw_pkg::tcw_cell_t  line_start;
	logic                out_free;
	logic                scan_issue;
	logic                sweep_last;
	logic                res_load;
	tcw_pkg::tcw_res_t   res_nxt;

	assign out_free   = !out_valid_q || res_pop;
	assign cmd_pop    = (state_q == ST_IDLE) && !cmd_empty && out_free;
	assign clearing   = (state_q == ST_CLEAR);
	assign scan_issue = (sweep_q != tcw_pkg::SCAN_END);
	assign sweep_last = (sweep_q == tcw_pkg::LAST_CELL);
	assign line_start = cursor_q - tcw_pkg::CELL_W'(col_q);

	always_comb begin
		nxt_cursor = cursor_q;
		nxt_col    = col_q;
		go_scroll  = 1'b0;
		if (cmd_pop) begin
			case (cmd_item.op)
				tcw_pkg::OP_PUT: begin
					if (cursor_q == tcw_pkg::LAST_CELL) begin
						nxt_cursor = tcw_pkg::LAST_ROW;
						nxt_col    = '0;
						go_scroll  = 1'b1;
					end else begin
						nxt_cursor = cursor_q + 1'b1;
						nxt_col    = (col_q == tcw_pkg::LAST_COL) ? '0 : col_q + 1'b1;
					end
				end
				tcw_pkg::OP_NEWLINE: begin
					nxt_col = '0;
					if (cursor_q >= tcw_pkg::LAST_ROW) begin
						nxt_cursor = tcw_pkg::LAST_ROW;
						go_scroll  = 1'b1;
					end else begin
						nxt_cursor = line_start + tcw_pkg::ROW_STRIDE;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = sweep_q;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = cmd_item.addr;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_IDLE: begin
				if (cmd_pop && cmd_item.op == tcw_pkg::OP_PUT) begin
					mem_we    = 1'b1;
					mem_waddr = cursor_q;
					mem_wdata = {colour_q, cmd_item.ch};
				end
				mem_re = cmd_pop && cmd_item.op == tcw_pkg::OP_READ && cmd_item.in_range;
			end
			ST_SCROLL: begin
				mem_raddr = sweep_q;
				mem_re    = scan_issue;
				mem_we    = rd_valid_s1;
				mem_waddr = rd_addr_s1 - tcw_pkg::ROW_STRIDE;
				mem_wdata = rd_data_q;
			end
			ST_FILL: begin
				mem_we    = 1'b1;
				mem_wdata = {colour_q, tcw_pkg::BLANK_CHAR};
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res_load = 1'b0;
		res_nxt.cursor_cell = nxt_cursor;
		res_nxt.read_char   = '0;
		res_nxt.read_attr   = '0;
		res_nxt.scrolled    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				res_load = cmd_pop && !go_scroll &&
					!(cmd_item.op == tcw_pkg::OP_READ && cmd_item.in_range);
			end
			ST_READ_WAIT: begin
				res_load          = 1'b1;
				res_nxt.read_char = rd_data_q[7:0];
				res_nxt.read_attr = rd_data_q[15:8];
			end
			ST_FILL: begin
				res_load         = sweep_last;
				res_nxt.scrolled = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			sweep_q     <= '0;
			cursor_q    <= '0;
			col_q       <= '0;
			colour_q    <= tcw_pkg::COLOUR_RESET;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				colour_q <= cfg_colour;
			end
			rd_valid_s1 <= (state_q == ST_SCROLL) && scan_issue;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (res_pop) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd_pop) begin
						cursor_q <= nxt_cursor;
						col_q    <= nxt_col;
						if (go_scroll) begin
							state_q <= ST_SCROLL;
							sweep_q <= tcw_pkg::ROW_STRIDE;
						end else if (mem_re) begin
							state_q <= ST_READ_WAIT;
						end
					end
				end
				ST_READ_WAIT: begin
					state_q <= ST_IDLE;
				end
				ST_SCROLL: begin
					if (scan_issue) begin
						sweep_q <= sweep_q + 1'b1;
					end else if (!rd_valid_s1) begin
						state_q <= ST_FILL;
						sweep_q <= tcw_pkg::LAST_ROW;
					end
				end
				ST_FILL: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_addr_s1 <= sweep_q;
		if (res_load) begin
			out_q <= res_nxt;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

`ifndef ASSERT_OFF
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q < tcw_pkg::SCAN_END)
		else $error("cursor left the screen");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> (state_q == ST_IDLE) && out_free)
		else $error("command taken outside idle or with result pending");

	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ_WAIT) |=> out_valid_q)
		else $error("read finished without a result");

	a_scroll_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL) && sweep_last |=> out_valid_q && out_q.scrolled)
		else $error("scroll finished without a scrolled result");

	a_scroll_dest: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCROLL) && rd_valid_s1 |-> rd_addr_s1 >= tcw_pkg::ROW_STRIDE)
		else $error("scroll copy below the first row");
`endif

endmodule

`default_nettype wire

@@ src/text_console_writer.sv @@
// Top level of the text console writer: input stage, command queue, screen engine.
// Depends on tcw_pkg, tcw_front, tcw_cmd_fifo and tcw_back.
//
// Channel   Direction  Handshake            Payload
// input     in         push / full          cmd, ch, cell_req
// result    out        pop / empty          cursor_cell, read_char, read_attr, scrolled
// config    in         cfg_valid / ready    colour
//
// A put, newline, ignored character or out-of-range read is handled in the idle state
// unless it scrolls; an in-range read passes through a wait state because the screen
// memory read data is registered. A scroll copies every row below the top one up a row
// through the memory's read and write ports and then refills the bottom row with blanks.
// After reset the memory is swept to zero with full high.
// The four-entry command queue and the result register let both sides stall independently.
`default_nettype none

module text_console_writer (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         push,
	output logic        full,
	input  wire         cmd,
	input  wire  [7:0]  ch,
	input  wire  [10:0] cell_req,
	output logic        empty,
	input  wire         pop,
	output logic [10:0] cursor_cell,
	output logic [7:0]  read_char,
	output logic [7:0]  read_attr,
	output logic        scrolled,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [7:0]  colour
);

	tcw_pkg::tcw_fifo_stat_t fifo_stat;
	tcw_pkg::tcw_cmd_t       push_item;
	tcw_pkg::tcw_cmd_t       head_item;
	tcw_pkg::tcw_res_t       res;
	logic                    cmd_push;
	logic                    cmd_pop;
	logic                    clearing;
	logic                    res_valid;
	logic                    res_pop;

	assign cfg_ready = 1'b1;

	tcw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.cmd       (cmd),
		.ch        (ch),
		.cell_req  (cell_req),
		.clearing  (clearing),
		.fifo_stat (fifo_stat),
		.cmd_push  (cmd_push),
		.cmd_item  (push_item)
	);

	tcw_cmd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (push_item),
		.rd_en   (cmd_pop),
		.rd_data (head_item),
		.stat    (fifo_stat)
	);

	tcw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid && cfg_ready),
		.cfg_colour (colour),
		.cmd_item   (head_item),
		.cmd_empty  (fifo_stat.empty),
		.cmd_pop    (cmd_pop),
		.clearing   (clearing),
		.res_valid  (res_valid),
		.res_pop    (res_pop),
		.res        (res)
	);

	assign empty       = !res_valid;
	assign res_pop     = pop && res_valid;
	assign cursor_cell = res.cursor_cell;
	assign read_char   = res.read_char;
	assign read_attr   = res.read_attr;
	assign scrolled    = res.scrolled;

endmodule

`default_nettype wire
